// File: design/qmi_pkg.sv
// Package for the quad mask IoU counter: widths, limits and shared types.
// No dependencies; every design file refers to it by scoped names.
package qmi_pkg;

  localparam int IMAGE_DIM   = 2048;
  localparam int CORNERS     = 4;
  localparam int COORD_W     = 13;
  localparam int PIX_W       = 11;
  localparam int COLOUR_W    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int COUNT_W     = 23;
  localparam int RATIO_SHIFT = 16;
  localparam int RATIO_W     = RATIO_SHIFT + 1;

  // Geometry widths: corner minus pixel fits 14 bits signed, products 28,
  // cross products 29 signed, absolute areas 28, sum of four areas 30.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int AREA_W  = PROD_W;
  localparam int QAREA_W = AREA_W + 1;
  localparam int SUM_W   = AREA_W + 2;

  // Queue between classifier and tally side.
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int DIV_STEPS = RATIO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [COLOUR_W-1:0] KEY_LEVEL = 8'd255;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_D_Y = 4'd7;

  // Classified pixel passed from front to back.
  typedef struct packed {
    logic in_quad;   // inside image and inside quad
    logic in_truth;  // inside image and colour-keyed
    logic last;      // frame end mark
  } cls_t;

endpackage

// File: design/qmi_front.sv
// Front end of the quad mask IoU counter: corner registers, pixel handshake
// and a three-stage classifier that pushes one cls_t per pixel. Uses qmi_pkg.
module qmi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qmi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [qmi_pkg::COORD_W-1:0]  cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [qmi_pkg::PIX_W-1:0]           in_pixel_row,
  input  logic [qmi_pkg::PIX_W-1:0]           in_pixel_col,
  input  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_blue,
  input  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_green,
  input  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_red,
  input  logic                                in_frame_end,
  output logic                                q_push,
  output qmi_pkg::cls_t                       q_wdata,
  input  logic                                q_pop
);

  localparam int NC = qmi_pkg::CORNERS;

  logic signed [qmi_pkg::COORD_W-1:0] cx_r [NC];
  logic signed [qmi_pkg::COORD_W-1:0] cy_r [NC];

  // credit: pixels accepted and not yet taken off the queue
  logic [qmi_pkg::QCNT_W-1:0] cred_r, cred_nxt;
  logic                       acc;

  // stage 1: corner minus pixel
  logic                              s1_v_r, s1_img_r, s1_tru_r, s1_last_r;
  logic signed [qmi_pkg::DIFF_W-1:0] dx_r [NC];
  logic signed [qmi_pkg::DIFF_W-1:0] dy_r [NC];
  // stage 2: edge products
  logic                              s2_v_r, s2_img_r, s2_tru_r, s2_last_r;
  logic signed [qmi_pkg::PROD_W-1:0] pa_r [NC];
  logic signed [qmi_pkg::PROD_W-1:0] pb_r [NC];
  // stage 3: absolute doubled triangle areas
  logic                              s3_v_r, s3_img_r, s3_tru_r, s3_last_r;
  logic [qmi_pkg::AREA_W-1:0]        ab_r [NC];

  // quad area, kept up to date from the corner registers
  logic signed [qmi_pkg::DIFF_W-1:0] ex_r [3];
  logic signed [qmi_pkg::DIFF_W-1:0] ey_r [3];
  logic signed [qmi_pkg::PROD_W-1:0] qp_r [4];
  logic [qmi_pkg::QAREA_W-1:0]       qa_r;

  logic signed [qmi_pkg::DIFF_W-1:0] px, py;
  logic                              img, tru;
  logic [qmi_pkg::SUM_W-1:0]         area_sum;
  logic signed [qmi_pkg::CROSS_W-1:0] qc1, qc2;
  logic [qmi_pkg::AREA_W-1:0]        qa1, qa2;

  function automatic logic [qmi_pkg::AREA_W-1:0] abs_cross(
    input logic signed [qmi_pkg::PROD_W-1:0] a,
    input logic signed [qmi_pkg::PROD_W-1:0] b
  );
    logic signed [qmi_pkg::CROSS_W-1:0] d;
    logic signed [qmi_pkg::CROSS_W-1:0] m;
    d = qmi_pkg::CROSS_W'(a) - qmi_pkg::CROSS_W'(b);
    m = d[qmi_pkg::CROSS_W-1] ? -d : d;
    return m[qmi_pkg::AREA_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_full   = (cred_r == qmi_pkg::QCNT_W'(qmi_pkg::QDEPTH));
  assign acc       = in_push && !in_full;

  always_comb begin
    cred_nxt = cred_r;
    if (acc && !q_pop) begin
      cred_nxt = cred_r + 1'b1;
    end else if (!acc && q_pop) begin
      cred_nxt = cred_r - 1'b1;
    end
  end

  assign px  = qmi_pkg::DIFF_W'({1'b0, in_pixel_col});
  assign py  = qmi_pkg::DIFF_W'({1'b0, in_pixel_row});
  assign img = (32'(in_pixel_row) < qmi_pkg::IMAGE_DIM) &&
               (32'(in_pixel_col) < qmi_pkg::IMAGE_DIM);
  assign tru = (in_truth_blue == qmi_pkg::KEY_LEVEL) && (in_truth_green == '0) &&
               (in_truth_red == qmi_pkg::KEY_LEVEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
    end else begin
      cred_r <= cred_nxt;
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      // indexes above the corner list are dropped
      if (cfg_valid && cfg_index <= qmi_pkg::REG_CORNER_D_Y) begin
        if (cfg_index[0]) begin
          cy_r[cfg_index[2:1]] <= cfg_data;
        end else begin
          cx_r[cfg_index[2:1]] <= cfg_data;
        end
      end
    end
  end

  // quad area pipeline; reset so it is settled by the first pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        ex_r[k] <= '0;
        ey_r[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        qp_r[k] <= '0;
      end
      qa_r <= '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        ex_r[k] <= qmi_pkg::DIFF_W'(cx_r[k+1]) - qmi_pkg::DIFF_W'(cx_r[0]);
        ey_r[k] <= qmi_pkg::DIFF_W'(cy_r[k+1]) - qmi_pkg::DIFF_W'(cy_r[0]);
      end
      qp_r[0] <= qmi_pkg::PROD_W'(ex_r[0]) * qmi_pkg::PROD_W'(ey_r[1]);
      qp_r[1] <= qmi_pkg::PROD_W'(ex_r[1]) * qmi_pkg::PROD_W'(ey_r[0]);
      qp_r[2] <= qmi_pkg::PROD_W'(ex_r[1]) * qmi_pkg::PROD_W'(ey_r[2]);
      qp_r[3] <= qmi_pkg::PROD_W'(ex_r[2]) * qmi_pkg::PROD_W'(ey_r[1]);
      qa_r    <= qmi_pkg::QAREA_W'(qa1) + qmi_pkg::QAREA_W'(qa2);
    end
  end

  assign qc1 = '0;
  assign qc2 = '0;
  assign qa1 = abs_cross(qp_r[0], qp_r[1]) | qmi_pkg::AREA_W'(qc1);
  assign qa2 = abs_cross(qp_r[2], qp_r[3]) | qmi_pkg::AREA_W'(qc2);

  // pixel datapath
  always_ff @(posedge clk) begin
    s1_img_r  <= img;
    s1_tru_r  <= tru && img;
    s1_last_r <= in_frame_end;
    for (int i = 0; i < NC; i++) begin
      dx_r[i] <= qmi_pkg::DIFF_W'(cx_r[i]) - px;
      dy_r[i] <= qmi_pkg::DIFF_W'(cy_r[i]) - py;
    end
    s2_img_r  <= s1_img_r;
    s2_tru_r  <= s1_tru_r;
    s2_last_r <= s1_last_r;
    for (int i = 0; i < NC; i++) begin
      pa_r[i] <= qmi_pkg::PROD_W'(dx_r[i]) * qmi_pkg::PROD_W'(dy_r[(i+1) % NC]);
      pb_r[i] <= qmi_pkg::PROD_W'(dx_r[(i+1) % NC]) * qmi_pkg::PROD_W'(dy_r[i]);
    end
    s3_img_r  <= s2_img_r;
    s3_tru_r  <= s2_tru_r;
    s3_last_r <= s2_last_r;
    for (int i = 0; i < NC; i++) begin
      ab_r[i] <= abs_cross(pa_r[i], pb_r[i]);
    end
  end

  always_comb begin
    area_sum = '0;
    for (int i = 0; i < NC; i++) begin
      area_sum = area_sum + qmi_pkg::SUM_W'(ab_r[i]);
    end
  end

  assign q_push           = s3_v_r;
  assign q_wdata.in_quad  = s3_img_r && (area_sum <= qmi_pkg::SUM_W'(qa_r));
  assign q_wdata.in_truth = s3_tru_r;
  assign q_wdata.last     = s3_last_r;

endmodule

// File: design/qmi_queue.sv
// Short queue of classified pixels between front and back ends.
// Uses qmi_pkg for depth and the entry type.
module qmi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qmi_pkg::cls_t wdata,
  input  logic          pop,
  output qmi_pkg::cls_t rdata,
  output logic          empty
);

  qmi_pkg::cls_t               mem_r [qmi_pkg::QDEPTH];
  logic [qmi_pkg::QPTR_W-1:0]  wr_r, rd_r;
  logic [qmi_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// File: design/qmi_back.sv
// Back end: saturating tallies, per-frame ratio by restoring division and
// the result register. Uses qmi_pkg.
module qmi_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  qmi_pkg::cls_t                q_rdata,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [qmi_pkg::COUNT_W-1:0]  out_overlap_count,
  output logic [qmi_pkg::COUNT_W-1:0]  out_union_count,
  output logic [qmi_pkg::RATIO_W-1:0]  out_iou_ratio
);

  localparam int CW = qmi_pkg::COUNT_W;
  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic                            st_r, st_nxt;
  logic [CW-1:0]                   ovt_r, unt_r, ovt_inc, unt_inc;
  logic [CW-1:0]                   sov_r, sun_r;
  logic [CW:0]                     rem_r, rem_sub;
  logic [qmi_pkg::RATIO_W-1:0]     quo_r;
  logic [qmi_pkg::DIV_CNT_W-1:0]   dcnt_r;
  logic                            qbit, div_done;
  logic                            ov_r;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == qmi_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  assign q_pop    = (st_r == ST_RUN) && !q_empty;
  assign ovt_inc  = (q_rdata.in_quad && q_rdata.in_truth) ? sat_inc(ovt_r) : ovt_r;
  assign unt_inc  = (q_rdata.in_quad || q_rdata.in_truth) ? sat_inc(unt_r) : unt_r;
  assign div_done = (dcnt_r == qmi_pkg::DIV_CNT_W'(qmi_pkg::DIV_STEPS));

  // remainder stays below twice the divisor, so one compare-subtract a step
  assign qbit    = (rem_r >= {1'b0, sun_r});
  assign rem_sub = qbit ? rem_r - {1'b0, sun_r} : rem_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_RUN: if (q_pop && q_rdata.last) st_nxt = ST_DIV;
      ST_DIV: if (div_done && !ov_r) st_nxt = ST_RUN;
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_RUN;
      ovt_r  <= '0;
      unt_r  <= '0;
      ov_r   <= 1'b0;
      dcnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop) begin
        if (q_rdata.last) begin
          ovt_r <= '0;
          unt_r <= '0;
        end else begin
          ovt_r <= ovt_inc;
          unt_r <= unt_inc;
        end
      end
      if (q_pop && q_rdata.last) begin
        dcnt_r <= '0;
      end else if (st_r == ST_DIV && !div_done) begin
        dcnt_r <= dcnt_r + 1'b1;
      end
      if (st_r == ST_DIV && div_done && !ov_r) begin
        ov_r <= 1'b1;
      end else if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_rdata.last) begin
      sov_r <= ovt_inc;
      sun_r <= unt_inc;
      rem_r <= {1'b0, ovt_inc};
      quo_r <= '0;
    end else if (st_r == ST_DIV && !div_done) begin
      rem_r <= {rem_sub[CW-1:0], 1'b0};
      quo_r <= {quo_r[qmi_pkg::RATIO_W-2:0], qbit};
    end
    if (st_r == ST_DIV && div_done && !ov_r) begin
      out_overlap_count <= sov_r;
      out_union_count   <= sun_r;
      out_iou_ratio     <= (sun_r == '0) ? '0 : quo_r;
    end
  end

  assign out_empty = !ov_r;

endmodule

// File: design/quad_mask_iou_counter_unit.sv
// Quad mask IoU counter, top level: front classifier, queue, back tally/divider.
// Throughput: one pixel per cycle while in_full is low; each frame end stops the
// tally side while the divider runs. A pixel goes through three classifier stages
// and the queue, longer while it is backed up; a frame result follows the divider.
// The tally side stops during the divider, so the queue fills and full rises.
// Reset (rst_n low, synchronous) clears corners, tallies, queue and result flag.
module quad_mask_iou_counter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qmi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [qmi_pkg::COORD_W-1:0]  cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [qmi_pkg::PIX_W-1:0]           in_pixel_row,
  input  logic [qmi_pkg::PIX_W-1:0]           in_pixel_col,
  input  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_blue,
  input  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_green,
  input  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_red,
  input  logic                                in_frame_end,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [qmi_pkg::COUNT_W-1:0]         out_overlap_count,
  output logic [qmi_pkg::COUNT_W-1:0]         out_union_count,
  output logic [qmi_pkg::RATIO_W-1:0]         out_iou_ratio
);

  logic          q_push, q_pop, q_empty;
  qmi_pkg::cls_t q_wdata, q_rdata;

  qmi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel_row   (in_pixel_row),
    .in_pixel_col   (in_pixel_col),
    .in_truth_blue  (in_truth_blue),
    .in_truth_green (in_truth_green),
    .in_truth_red   (in_truth_red),
    .in_frame_end   (in_frame_end),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_pop          (q_pop)
  );

  qmi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  qmi_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_overlap_count (out_overlap_count),
    .out_union_count   (out_union_count),
    .out_iou_ratio     (out_iou_ratio)
  );

endmodule

// File: design/qmi_checker.sv
// Port-level checks for the quad mask IoU counter, bound to the top level.
// Uses qmi_pkg for field widths.
module qmi_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_full,
  input logic                               out_empty,
  input logic                               out_pop,
  input logic [qmi_pkg::COUNT_W-1:0]        out_overlap_count,
  input logic [qmi_pkg::COUNT_W-1:0]        out_union_count,
  input logic [qmi_pkg::RATIO_W-1:0]        out_iou_ratio
);

  // after reset nothing is queued and no result waits
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result or full flag set after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      ($stable(out_overlap_count) && $stable(out_union_count) && $stable(out_iou_ratio)))
    else $error("waiting result changed");

  a_subset: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_overlap_count <= out_union_count)
    else $error("overlap exceeds union");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_iou_ratio <= qmi_pkg::RATIO_W'(1 << qmi_pkg::RATIO_SHIFT))
    else $error("ratio above one");

  a_empty_union: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_union_count == '0) |-> out_iou_ratio == '0)
    else $error("non-zero ratio for empty union");

endmodule

bind quad_mask_iou_counter_unit qmi_checker u_qmi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_overlap_count (out_overlap_count),
  .out_union_count   (out_union_count),
  .out_iou_ratio     (out_iou_ratio)
);

// File: sim/tb_quad_mask_iou_counter_unit.sv
// Testbench for quad_mask_iou_counter_unit: directed and random pixel frames,
// each frame result checked against an in-bench IoU tally predictor.
// Depends on qmi_pkg and the design sources only.
module tb_quad_mask_iou_counter_unit;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 150;

  typedef enum logic [qmi_pkg::CFG_IDX_W-1:0] {
    CORNER_A_X = qmi_pkg::REG_CORNER_A_X,
    CORNER_A_Y,
    CORNER_B_X,
    CORNER_B_Y,
    CORNER_C_X,
    CORNER_C_Y,
    CORNER_D_X,
    CORNER_D_Y
  } corner_reg_e;

  typedef enum int {SHAPE_RECT, SHAPE_NEAR, SHAPE_WIDE} quad_shape_e;

  typedef struct packed {
    logic [qmi_pkg::PIX_W-1:0]    row;
    logic [qmi_pkg::PIX_W-1:0]    col;
    logic [qmi_pkg::COLOUR_W-1:0] blue;
    logic [qmi_pkg::COLOUR_W-1:0] green;
    logic [qmi_pkg::COLOUR_W-1:0] red;
    logic                         frame_end;
  } pixel_t;

  typedef struct packed {
    logic [qmi_pkg::COUNT_W-1:0] overlap;
    logic [qmi_pkg::COUNT_W-1:0] union_cnt;
    logic [qmi_pkg::RATIO_W-1:0] ratio;
  } frame_result_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [qmi_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic signed [qmi_pkg::COORD_W-1:0]  cfg_data;
  logic                                in_push;
  logic                                in_full;
  logic [qmi_pkg::PIX_W-1:0]           in_pixel_row;
  logic [qmi_pkg::PIX_W-1:0]           in_pixel_col;
  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_blue;
  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_green;
  logic [qmi_pkg::COLOUR_W-1:0]        in_truth_red;
  logic                                in_frame_end;
  logic                                out_empty;
  logic                                out_pop = 1'b0;
  logic [qmi_pkg::COUNT_W-1:0]         out_overlap_count;
  logic [qmi_pkg::COUNT_W-1:0]         out_union_count;
  logic [qmi_pkg::RATIO_W-1:0]         out_iou_ratio;

  // Predictor state: corners as the block holds them, running tallies.
  logic signed [qmi_pkg::COORD_W-1:0] quad_x [qmi_pkg::CORNERS];
  logic signed [qmi_pkg::COORD_W-1:0] quad_y [qmi_pkg::CORNERS];
  logic [qmi_pkg::COUNT_W-1:0]        overlap_tally;
  logic [qmi_pkg::COUNT_W-1:0]        union_tally;
  frame_result_t                      expected_frames [$];

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  quad_mask_iou_counter_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel_row      (in_pixel_row),
    .in_pixel_col      (in_pixel_col),
    .in_truth_blue     (in_truth_blue),
    .in_truth_green    (in_truth_green),
    .in_truth_red      (in_truth_red),
    .in_frame_end      (in_frame_end),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_overlap_count (out_overlap_count),
    .out_union_count   (out_union_count),
    .out_iou_ratio     (out_iou_ratio)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // Doubled absolute area of a triangle.
  function automatic longint area2(longint x1, longint y1, longint x2, longint y2,
                                   longint x3, longint y3);
    longint s;
    s = x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2);
    return (s < 0) ? -s : s;
  endfunction

  function automatic bit pixel_in_quad(longint px, longint py);
    longint quad_area;
    longint side_sum;
    longint vx [qmi_pkg::CORNERS];
    longint vy [qmi_pkg::CORNERS];
    int     nxt;
    for (int i = 0; i < qmi_pkg::CORNERS; i++) begin
      vx[i] = longint'(quad_x[i]);
      vy[i] = longint'(quad_y[i]);
    end
    quad_area = area2(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2])
              + area2(vx[0], vy[0], vx[2], vy[2], vx[3], vy[3]);
    side_sum = 0;
    for (int i = 0; i < qmi_pkg::CORNERS; i++) begin
      nxt = (i + 1) % qmi_pkg::CORNERS;
      side_sum += area2(px, py, vx[i], vy[i], vx[nxt], vy[nxt]);
    end
    return side_sum <= quad_area;
  endfunction

  function automatic void tally_pixel(pixel_t p);
    bit            in_quad;
    bit            keyed;
    frame_result_t res;
    if (p.row < qmi_pkg::IMAGE_DIM && p.col < qmi_pkg::IMAGE_DIM) begin
      in_quad = pixel_in_quad(longint'(p.col), longint'(p.row));
      keyed  = p.blue == qmi_pkg::KEY_LEVEL && p.green == '0 && p.red == qmi_pkg::KEY_LEVEL;
      if (in_quad && keyed && overlap_tally != qmi_pkg::COUNT_MAX)
        overlap_tally = overlap_tally + 1'b1;
      if ((in_quad || keyed) && union_tally != qmi_pkg::COUNT_MAX)
        union_tally = union_tally + 1'b1;
    end
    if (p.frame_end) begin
      res.overlap   = overlap_tally;
      res.union_cnt = union_tally;
      res.ratio     = '0;
      if (union_tally != '0)
        res.ratio = qmi_pkg::RATIO_W'((longint'(overlap_tally) << qmi_pkg::RATIO_SHIFT) /
                                      longint'(union_tally));
      expected_frames = {expected_frames, res};
      overlap_tally = '0;
      union_tally   = '0;
    end
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void compare_field(string name, logic [qmi_pkg::COUNT_W-1:0] want,
                                        logic [qmi_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(negedge clk) out_pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result: overlap %0d union %0d ratio %0d",
               out_overlap_count, out_union_count, out_iou_ratio);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        compare_field("overlap_count", want.overlap, out_overlap_count);
        compare_field("union_count", want.union_cnt, out_union_count);
        compare_field("iou_ratio", qmi_pkg::COUNT_W'(want.ratio),
                      qmi_pkg::COUNT_W'(out_iou_ratio));
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic push_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push        = 1'b1;
    in_pixel_row   = p.row;
    in_pixel_col   = p.col;
    in_truth_blue  = p.blue;
    in_truth_green = p.green;
    in_truth_red   = p.red;
    in_frame_end   = p.frame_end;
    do @(posedge clk); while (in_full);
    tally_pixel(p);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [qmi_pkg::CFG_IDX_W-1:0] idx,
                                input logic signed [qmi_pkg::COORD_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    // indexes past the last corner register are dropped by the block
    if (idx <= CORNER_D_Y) begin
      if (idx[0])
        quad_y[idx >> 1] = data;
      else
        quad_x[idx >> 1] = data;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_quad(input int ax, ay, bx, by, cx, cy, dx, dy);
    write_register(CORNER_A_X, qmi_pkg::COORD_W'(ax));
    write_register(CORNER_A_Y, qmi_pkg::COORD_W'(ay));
    write_register(CORNER_B_X, qmi_pkg::COORD_W'(bx));
    write_register(CORNER_B_Y, qmi_pkg::COORD_W'(by));
    write_register(CORNER_C_X, qmi_pkg::COORD_W'(cx));
    write_register(CORNER_C_Y, qmi_pkg::COORD_W'(cy));
    write_register(CORNER_D_X, qmi_pkg::COORD_W'(dx));
    write_register(CORNER_D_Y, qmi_pkg::COORD_W'(dy));
  endtask

  // Settle: all results in, then time for pixels that produce none to clear.
  task automatic wait_drained();
    in_push = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic pixel_t pixel_at(int row, int col, int b, int g, int r, bit last);
    pixel_t p;
    p.row       = qmi_pkg::PIX_W'(row);
    p.col       = qmi_pkg::PIX_W'(col);
    p.blue      = qmi_pkg::COLOUR_W'(b);
    p.green     = qmi_pkg::COLOUR_W'(g);
    p.red       = qmi_pkg::COLOUR_W'(r);
    p.frame_end = last;
    return p;
  endfunction

  function automatic int rand_coord(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [qmi_pkg::PIX_W-1:0] clamp_pix(int v);
    if (v < 0)
      return '0;
    if (v > qmi_pkg::IMAGE_DIM - 1)
      return qmi_pkg::PIX_W'(qmi_pkg::IMAGE_DIM - 1);
    return qmi_pkg::PIX_W'(v);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     pick;
    int     k;
    p.row = qmi_pkg::PIX_W'($urandom_range(qmi_pkg::IMAGE_DIM - 1));
    p.col = qmi_pkg::PIX_W'($urandom_range(qmi_pkg::IMAGE_DIM - 1));
    // bias some pixels towards a corner so the quad boundary gets exercised
    if ($urandom_range(99) < 30) begin
      pick  = $urandom_range(qmi_pkg::CORNERS - 1);
      p.col = clamp_pix(int'(quad_x[pick]) + rand_coord(-3, 3));
      p.row = clamp_pix(int'(quad_y[pick]) + rand_coord(-3, 3));
    end
    p.blue  = qmi_pkg::KEY_LEVEL;
    p.green = '0;
    p.red   = qmi_pkg::KEY_LEVEL;
    k = $urandom_range(99);
    if (k >= 75) begin
      p.blue  = qmi_pkg::COLOUR_W'($urandom);
      p.green = qmi_pkg::COLOUR_W'($urandom);
      p.red   = qmi_pkg::COLOUR_W'($urandom);
    end else if (k >= 50) begin
      // near miss on the colour key: one bit of one channel off
      pick = $urandom_range(qmi_pkg::COLOUR_W - 1);
      case ($urandom_range(2))
        0: p.blue[pick] = ~p.blue[pick];
        1: p.green[pick] = ~p.green[pick];
        default: p.red[pick] = ~p.red[pick];
      endcase
    end
    p.frame_end = 1'b0;
    return p;
  endfunction

  task automatic random_quad(input quad_shape_e shape);
    int x0, y0, x1, y1;
    case (shape)
      SHAPE_RECT: begin
        x0 = rand_coord(-50, 1900);
        y0 = rand_coord(-50, 1900);
        x1 = x0 + rand_coord(1, 600);
        y1 = y0 + rand_coord(1, 600);
        set_quad(x0, y0, x1, y0, x1, y1, x0, y1);
      end
      SHAPE_NEAR: begin
        set_quad(rand_coord(-300, 2350), rand_coord(-300, 2350),
                 rand_coord(-300, 2350), rand_coord(-300, 2350),
                 rand_coord(-300, 2350), rand_coord(-300, 2350),
                 rand_coord(-300, 2350), rand_coord(-300, 2350));
      end
      default: begin
        set_quad(rand_coord(-4096, 4095), rand_coord(-4096, 4095),
                 rand_coord(-4096, 4095), rand_coord(-4096, 4095),
                 rand_coord(-4096, 4095), rand_coord(-4096, 4095),
                 rand_coord(-4096, 4095), rand_coord(-4096, 4095));
      end
    endcase
  endtask

  task automatic run_random_phase(input int send_pct, input int pop_pct,
                                  input quad_shape_e shape, input bit hold_off);
    int     sent;
    int     frame_len;
    pixel_t p;
    wait_drained();
    send_idle_pct = send_pct;
    pop_stall_pct = pop_pct;
    random_quad(shape);
    if ($urandom_range(1))
      write_register(qmi_pkg::CFG_IDX_W'(rand_coord(CORNER_D_Y + 1,
                                                    2 ** qmi_pkg::CFG_IDX_W - 1)),
                     qmi_pkg::COORD_W'($urandom));
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      frame_len = $urandom_range(24, 1);
      for (int k = 0; k < frame_len; k++) begin
        p = random_pixel();
        p.frame_end = (k == frame_len - 1);
        push_pixel(p);
        sent++;
      end
      // sender holds back until the block has handed over every frame
      if (hold_off && sent >= PHASE_ITEMS / 2) begin
        in_push = 1'b0;
        while (expected_frames.size() != 0) @(negedge clk);
        hold_off = 1'b0;
      end
    end
  endtask

  // -------------------------------------------------------------------- tests

  // Reset corners all coincide, so every pixel is inside the quad.
  task automatic test_reset_quad();
    push_pixel(pixel_at(0, 0, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(2047, 2047, 0, 0, 0, 1'b0));
    push_pixel(pixel_at(0, 2047, 255, 1, 255, 1'b0));
    push_pixel(pixel_at(2047, 0, 255, 0, 255, 1'b1));
  endtask

  task automatic test_degenerate_quads();
    wait_drained();
    // zero-area segment off the image: no pixel inside, empty union in the first frame
    set_quad(-4096, -4096, -4096, -4096, 4095, -4096, 4095, -4096);
    push_pixel(pixel_at(7, 5, 0, 0, 0, 1'b0));
    push_pixel(pixel_at(0, 0, 255, 255, 255, 1'b1));
    push_pixel(pixel_at(3, 3, 255, 0, 255, 1'b1));
    wait_drained();
    // segment along row zero: only pixels on it count as inside
    set_quad(0, 0, 0, 0, 2047, 0, 2047, 0);
    push_pixel(pixel_at(0, 100, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(1, 100, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(0, 2047, 0, 0, 0, 1'b1));
  endtask

  task automatic test_quad_extremes();
    wait_drained();
    set_quad(-4096, -4096, 4095, -4096, 4095, 4095, -4096, 4095);
    push_pixel(pixel_at(0, 0, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(2047, 2047, 255, 0, 255, 1'b1));
    wait_drained();
    set_quad(10, 10, 20, 10, 20, 20, 10, 20);
    push_pixel(pixel_at(10, 10, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(20, 15, 0, 0, 0, 1'b0));
    push_pixel(pixel_at(15, 21, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(15, 15, 255, 255, 255, 1'b1));
  endtask

  task automatic test_ignored_index();
    wait_drained();
    for (int i = CORNER_D_Y + 1; i < 2 ** qmi_pkg::CFG_IDX_W; i++)
      write_register(qmi_pkg::CFG_IDX_W'(i), qmi_pkg::COORD_W'($urandom));
    push_pixel(pixel_at(12, 12, 255, 0, 255, 1'b0));
    push_pixel(pixel_at(30, 30, 0, 0, 0, 1'b0));
    push_pixel(pixel_at(2047, 0, 255, 0, 255, 1'b1));
  endtask

  task automatic test_random_frames();
    run_random_phase(0, 0, SHAPE_RECT, 1'b0);
    run_random_phase(47, 0, SHAPE_NEAR, 1'b1);
    run_random_phase(0, 47, SHAPE_WIDE, 1'b0);
    run_random_phase(33, 33, SHAPE_NEAR, 1'b0);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CORNER_A_X;
    cfg_data       = '0;
    in_push        = 1'b0;
    in_pixel_row   = '0;
    in_pixel_col   = '0;
    in_truth_blue  = '0;
    in_truth_green = '0;
    in_truth_red   = '0;
    in_frame_end   = 1'b0;
    overlap_tally  = '0;
    union_tally    = '0;
    for (int i = 0; i < qmi_pkg::CORNERS; i++) begin
      quad_x[i] = '0;
      quad_y[i] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    pop_stall_pct = 20;

    test_reset_quad();
    test_degenerate_quads();
    test_quad_extremes();
    test_ignored_index();
    test_random_frames();

    wait_drained();
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: quad_mask_iou_counter_unit.f
design/qmi_pkg.sv
design/qmi_front.sv
design/qmi_queue.sv
design/qmi_back.sv
design/quad_mask_iou_counter_unit.sv
design/qmi_checker.sv
sim/tb_quad_mask_iou_counter_unit.sv
